[rtl/core/jsu_pkg.sv]
// Shared types, codes and helpers for the JSON string unescaper.
package jsu_pkg;

    // Result slots one text byte can cause: three UTF-8 bytes plus an end status
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_W      = $clog2(MAX_RESULTS);

    // Default depth of the result bundle queue (power of two, at least 2)
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;

    localparam logic [7:0] UTF8_CONT    = 8'h80;
    localparam logic [7:0] UTF8_LEAD2   = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3   = 8'hE0;

    typedef enum logic [2:0] {
        MODE_AWAIT  = 3'd0,
        MODE_STRING = 3'd1,
        MODE_ESCAPE = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_DONE   = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_DATA     = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_NOTSTR   = 3'd2,
        ST_BADESC   = 3'd3,
        ST_BADHEX   = 3'd4,
        ST_UNTERM   = 3'd5
    } status_t;

    // All results caused by one text byte
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        status_t [MAX_RESULTS-1:0]   stat;
        logic [SLOT_W-1:0]           last_slot;
    } bundle_t;

    // Hex digit decode; valid is low for a non-hex byte
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    // Simple escape map; valid is low for an unknown escape letter
    typedef struct packed {
        logic       valid;
        logic [7:0] value;
    } esc_t;

    function automatic esc_t escape_map(input logic [7:0] c);
        esc_t e;
        e.valid = 1'b1;
        e.value = 8'h00;
        unique case (c)
            CH_QUOTE:     e.value = CH_QUOTE;
            CH_BACKSLASH: e.value = CH_BACKSLASH;
            CH_SLASH:     e.value = CH_SLASH;
            8'h6E:        e.value = 8'h0A;
            8'h72:        e.value = 8'h0D;
            8'h74:        e.value = 8'h09;
            8'h62:        e.value = 8'h08;
            8'h66:        e.value = 8'h0C;
            default:      e.valid = 1'b0;
        endcase
        return e;
    endfunction

endpackage

[rtl/core/json_string_unescaper.sv]
// JSON string unescaper: byte decoder with a queue of per-byte result bundles.
//
//  channel | dir | ports                                  | carries
//  --------+-----+----------------------------------------+------------------------------
//  s_      | in  | s_valid s_ready s_data_byte            | one byte of JSON text
//          |     | s_start_new s_text_ends                |
//  m_      | out | m_valid m_ready m_out_byte m_status    | one decoded byte or a status
//          |     | m_last                                 |
//
// Cycles: one text byte per cycle while the queue has room; its 0..4 results enter the bundle
// queue in one pass and are registered before leaving, one per cycle while m_ready is high.
// A \u escape spends six text bytes for at most four results, so one byte per cycle holds.
// Reset (aresetn low, synchronous) awaits the opening quote and empties the queue.
// A stalled m_ready holds the head result; s_ready drops only when the queue is full.
module json_string_unescaper #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_start_new,
    input  logic       s_text_ends,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [2:0] m_status,
    output logic       m_last
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W = jsu_pkg::SLOT_W;

    // Parse state
    jsu_pkg::mode_t mode_reg, mode_next;
    logic [1:0]     hex_cnt_reg, hex_cnt_next;
    logic [15:0]    code_reg, code_next;

    // Result bundle queue
    jsu_pkg::bundle_t  queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] slot_reg;

    jsu_pkg::bundle_t  bundle;
    jsu_pkg::bundle_t  head;
    logic [2:0]        res_cnt;
    logic              s_fire, m_fire, push, pop;

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign s_fire  = s_valid && s_ready;
    assign push    = s_fire && (res_cnt != 3'd0);

    assign head       = queue_mem[rd_ptr_reg];
    assign m_valid    = (count_reg != '0);
    assign m_out_byte = head.bytes[slot_reg];
    assign m_status   = head.stat[slot_reg];
    assign m_last     = (slot_reg == head.last_slot);
    assign m_fire     = m_valid && m_ready;
    assign pop        = m_fire && m_last;

    // Decode one text byte: next parse state and the bundle of results it causes.
    always_comb begin
        jsu_pkg::hex_t hd;
        jsu_pkg::esc_t es;
        logic [15:0]   cp;

        hd = jsu_pkg::hex_decode(s_data_byte);
        es = jsu_pkg::escape_map(s_data_byte);
        cp = {code_reg[11:0], hd.value};

        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        code_next    = code_reg;
        res_cnt      = 3'd0;
        bundle.bytes = '0;
        bundle.stat  = '{default: jsu_pkg::ST_DATA};

        if (s_start_new || mode_reg == jsu_pkg::MODE_AWAIT) begin
            // Restart: abandon any open string and check for the opening quote
            hex_cnt_next = 2'd0;
            code_next    = 16'd0;
            if (s_data_byte == jsu_pkg::CH_QUOTE) begin
                mode_next = jsu_pkg::MODE_STRING;
            end else begin
                mode_next                 = jsu_pkg::MODE_DONE;
                bundle.stat[res_cnt[1:0]] = jsu_pkg::ST_NOTSTR;
                res_cnt                   = res_cnt + 3'd1;
            end
        end else begin
            unique case (mode_reg)
                jsu_pkg::MODE_STRING: begin
                    if (s_data_byte == jsu_pkg::CH_QUOTE) begin
                        mode_next                 = jsu_pkg::MODE_DONE;
                        bundle.stat[res_cnt[1:0]] = jsu_pkg::ST_COMPLETE;
                        res_cnt                   = res_cnt + 3'd1;
                    end else if (s_data_byte == jsu_pkg::CH_BACKSLASH) begin
                        mode_next = jsu_pkg::MODE_ESCAPE;
                    end else begin
                        bundle.bytes[res_cnt[1:0]] = s_data_byte;
                        res_cnt                    = res_cnt + 3'd1;
                    end
                end
                jsu_pkg::MODE_ESCAPE: begin
                    if (s_data_byte == jsu_pkg::CH_LOWER_U) begin
                        mode_next    = jsu_pkg::MODE_HEX;
                        hex_cnt_next = 2'd0;
                        code_next    = 16'd0;
                    end else if (es.valid) begin
                        mode_next                  = jsu_pkg::MODE_STRING;
                        bundle.bytes[res_cnt[1:0]] = es.value;
                        res_cnt                    = res_cnt + 3'd1;
                    end else begin
                        mode_next                 = jsu_pkg::MODE_DONE;
                        bundle.stat[res_cnt[1:0]] = jsu_pkg::ST_BADESC;
                        res_cnt                   = res_cnt + 3'd1;
                    end
                end
                jsu_pkg::MODE_HEX: begin
                    if (!hd.valid) begin
                        mode_next                 = jsu_pkg::MODE_DONE;
                        bundle.stat[res_cnt[1:0]] = jsu_pkg::ST_BADHEX;
                        res_cnt                   = res_cnt + 3'd1;
                    end else begin
                        code_next = cp;
                        if (hex_cnt_reg == 2'd3) begin
                            // Fourth digit: emit the code point as UTF-8
                            hex_cnt_next = 2'd0;
                            mode_next    = jsu_pkg::MODE_STRING;
                            if (cp < 16'h0080) begin
                                bundle.bytes[0] = cp[7:0];
                                res_cnt         = 3'd1;
                            end else if (cp < 16'h0800) begin
                                bundle.bytes[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
                                bundle.bytes[1] = jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
                                res_cnt         = 3'd2;
                            end else begin
                                bundle.bytes[0] = jsu_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]};
                                bundle.bytes[1] = jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]};
                                bundle.bytes[2] = jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
                                res_cnt         = 3'd3;
                            end
                        end else begin
                            hex_cnt_next = hex_cnt_reg + 2'd1;
                        end
                    end
                end
                default: begin
                    // Finished (and unreachable codes): drop the byte silently
                end
            endcase
        end

        // Text ran out with the string still open: append the unterminated status
        if (s_text_ends && (mode_next == jsu_pkg::MODE_STRING ||
                            mode_next == jsu_pkg::MODE_ESCAPE ||
                            mode_next == jsu_pkg::MODE_HEX)) begin
            mode_next                 = jsu_pkg::MODE_DONE;
            bundle.stat[res_cnt[1:0]] = jsu_pkg::ST_UNTERM;
            res_cnt                   = res_cnt + 3'd1;
        end

        bundle.last_slot = SLOT_W'(res_cnt - 3'd1);
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push && pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= jsu_pkg::MODE_AWAIT;
            hex_cnt_reg <= 2'd0;
            code_reg    <= 16'd0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            slot_reg    <= '0;
        end else begin
            if (s_fire) begin
                mode_reg    <= mode_next;
                hex_cnt_reg <= hex_cnt_next;
                code_reg    <= code_next;
            end
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
                slot_reg   <= '0;
            end else if (m_fire) begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Queue storage: hold bundles until their last result leaves
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= bundle;
        end
    end

endmodule

[rtl/core/jsu_checker.sv]
// Port-level checker for the JSON string unescaper, bound to the top level.
module jsu_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic [2:0] m_status,
    input logic       m_last
);

    // Hold a stalled result steady
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_status)
                                && $stable(m_last))
        else $error("result changed while stalled");

    // Any status other than data ends the results of its byte
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != jsu_pkg::ST_DATA |-> m_last)
        else $error("status result not marked last");

    // Status results carry a zero byte
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != jsu_pkg::ST_DATA |-> m_out_byte == 8'h00)
        else $error("status result carries a byte");

    // Status codes stay within the defined set
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= jsu_pkg::ST_UNTERM)
        else $error("status out of range");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_status   (m_status),
    .m_last     (m_last)
);
